// ===== sv/tjpl_pkg.sv =====
// Package for the trapezoid jitter profile with loss block.
// Holds widths, register indexes, state types and the multiply/divide
// request and response structs. No dependencies.
`default_nettype none

package tjpl_pkg;

    // Time arithmetic width (modulo 2^TIME_W), legal range 32..64
    localparam int TIME_W    = 48;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = ((TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W  = 32;
    localparam int HOLD_W    = 33;  // rise + hold
    localparam int SPAN_W    = 34;  // rise + hold + fall
    localparam int WIDE_W    = (TIME_W > SPAN_W) ? TIME_W : SPAN_W;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_MOVE,
        ST_OFFSET,
        ST_PHASE,
        ST_MULT,
        ST_DIVIDE,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic              start;
        logic [CFG_W-1:0]  multiplicand;
        logic [CFG_W-1:0]  multiplier;
        logic [CFG_W-1:0]  divisor;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [CFG_W-1:0]  quotient;
    } md_rsp_t;

endpackage

`default_nettype wire

// ===== sv/tjpl_muldiv.sv =====
// Shared multiply/divide unit: floor(a * b / d) with the quotient known
// to fit 32 bits. A multiply step, then one restoring divide step a cycle.
// Depends on tjpl_pkg.
`default_nettype none

module tjpl_muldiv (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tjpl_pkg::md_req_t req,
    output tjpl_pkg::md_rsp_t      rsp
);

    tjpl_pkg::md_state_t                 state_reg, state_next;
    logic [tjpl_pkg::CFG_W-1:0]          a_reg, a_next;
    logic [tjpl_pkg::CFG_W-1:0]          b_reg, b_next;
    logic [tjpl_pkg::CFG_W-1:0]          d_reg, d_next;
    logic [tjpl_pkg::CFG_W-1:0]          rem_reg, rem_next;
    logic [tjpl_pkg::CFG_W-1:0]          quo_reg, quo_next;
    logic [tjpl_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                done_reg, done_next;

    logic [2*tjpl_pkg::CFG_W-1:0]        product;
    logic [tjpl_pkg::CFG_W:0]            trial;
    logic [tjpl_pkg::CFG_W:0]            trial_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tjpl_pkg::MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;

        product   = a_reg * b_reg;
        // shift the next dividend bit in, then trial subtract
        trial     = {rem_reg, quo_reg[tjpl_pkg::CFG_W-1]};
        trial_sub = trial - {1'b0, d_reg};

        unique case (state_reg)
            tjpl_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.multiplicand;
                    b_next     = req.multiplier;
                    d_next     = req.divisor;
                    state_next = tjpl_pkg::MD_MUL;
                end
            end
            tjpl_pkg::MD_MUL:
            begin
                rem_next   = product[2*tjpl_pkg::CFG_W-1:tjpl_pkg::CFG_W];
                quo_next   = product[tjpl_pkg::CFG_W-1:0];
                cnt_next   = '0;
                state_next = tjpl_pkg::MD_DIV;
            end
            tjpl_pkg::MD_DIV:
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    rem_next = trial_sub[tjpl_pkg::CFG_W-1:0];
                    quo_next = {quo_reg[tjpl_pkg::CFG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[tjpl_pkg::CFG_W-1:0];
                    quo_next = {quo_reg[tjpl_pkg::CFG_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tjpl_pkg::DIV_CNT_W'(tjpl_pkg::DIV_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = tjpl_pkg::MD_IDLE;
                end
            end
            default:
            begin
                state_next = tjpl_pkg::MD_IDLE;
            end
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/trapezoid_jitter_profile_with_loss_unit.sv =====
// Top level of the trapezoid jitter profile with loss block: sequencer,
// window state, configuration registers and output register.
// Depends on tjpl_pkg and tjpl_muldiv.
`default_nettype none

// Each input item is one packet arrival time; each yields one result item
// (drop flag, added delay). s_tready is high only while the sequencer is idle,
// so one item is in work at a time. An item on a ramp passes five sequencer
// steps up to the divider start, a multiply step and 32 restoring divide steps
// in the shared multiply/divide unit, then steps that take the quotient, load
// the output register and accept again. A packet past the window end takes the
// same path, dividing a zero remainder. Items in the hold phase or on a
// zero-length ramp skip the multiply/divide unit, items before the window start
// leave after the offset step, and items with a zero amplitude skip the window
// steps. A finished result sits in the output register until taken, and the
// next item is accepted meanwhile. Writes to the listed configuration registers
// restart the window at the next item.
module trapezoid_jitter_profile_with_loss_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input item: now_us
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tjpl_pkg::S_DATA_W-1:0]     s_tdata,   // [47:0] now_us
    // result item
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tjpl_pkg::M_DATA_W-1:0]          m_tdata,   // [31:0] delay_us
    output logic                                   m_tuser,   // [0] drop
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [tjpl_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [tjpl_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int TW = tjpl_pkg::TIME_W;
    localparam int CW = tjpl_pkg::CFG_W;
    localparam int WW = tjpl_pkg::WIDE_W;

    tjpl_pkg::ctrl_state_t          state_reg, state_next;

    logic [CW-1:0]                  amp_reg, amp_next;
    logic [CW-1:0]                  rise_reg, rise_next;
    logic [CW-1:0]                  hold_reg, hold_next;
    logic [CW-1:0]                  fall_reg, fall_next;
    logic [CW-1:0]                  loss_reg, loss_next;
    logic [CW-1:0]                  period_reg, period_next;
    logic [tjpl_pkg::HOLD_W-1:0]    rh_reg, rh_next;
    logic [tjpl_pkg::SPAN_W-1:0]    total_reg, total_next;

    logic [TW-1:0]                  ws_reg, ws_next;
    logic [TW-1:0]                  we_reg, we_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           restart_reg, restart_next;

    logic [TW-1:0]                  now_reg, now_next;
    logic                           after_end_reg, after_end_next;
    logic [TW-1:0]                  diff_reg, diff_next;
    logic [TW-1:0]                  x_reg, x_next;
    logic [CW-1:0]                  num_reg, num_next;
    logic [CW-1:0]                  den_reg, den_next;
    logic                           res_drop_reg, res_drop_next;
    logic [CW-1:0]                  res_delay_reg, res_delay_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_drop_reg, out_drop_next;
    logic [CW-1:0]                  out_delay_reg, out_delay_next;

    logic [TW-1:0]                  now_in;
    logic [WW-1:0]                  x_wide;
    logic [WW-1:0]                  rem_wide;
    logic [CW-1:0]                  count_inc;
    logic                           cfg_hit;

    tjpl_pkg::md_req_t              md_req;
    tjpl_pkg::md_rsp_t              md_rsp;

    tjpl_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tjpl_pkg::ST_IDLE;
            amp_reg       <= '0;
            rise_reg      <= '0;
            hold_reg      <= '0;
            fall_reg      <= '0;
            loss_reg      <= '0;
            period_reg    <= '0;
            rh_reg        <= '0;
            total_reg     <= '0;
            ws_reg        <= '0;
            we_reg        <= '0;
            count_reg     <= '0;
            restart_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            amp_reg       <= amp_next;
            rise_reg      <= rise_next;
            hold_reg      <= hold_next;
            fall_reg      <= fall_next;
            loss_reg      <= loss_next;
            period_reg    <= period_next;
            rh_reg        <= rh_next;
            total_reg     <= total_next;
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            count_reg     <= count_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        after_end_reg <= after_end_next;
        diff_reg      <= diff_next;
        x_reg         <= x_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        res_drop_reg  <= res_drop_next;
        res_delay_reg <= res_delay_next;
        out_drop_reg  <= out_drop_next;
        out_delay_reg <= out_delay_next;
    end

    // Configuration registers and the span sums derived from them
    always_comb
    begin
        amp_next    = amp_reg;
        rise_next   = rise_reg;
        hold_next   = hold_reg;
        fall_next   = fall_reg;
        loss_next   = loss_reg;
        period_next = period_reg;
        cfg_hit     = 1'b0;
        if (cfg_wr_en)
        begin
            cfg_hit = 1'b1;
            unique case (cfg_addr)
                tjpl_pkg::REG_AMPLITUDE: amp_next    = cfg_wdata;
                tjpl_pkg::REG_RISE:      rise_next   = cfg_wdata;
                tjpl_pkg::REG_HOLD:      hold_next   = cfg_wdata;
                tjpl_pkg::REG_FALL:      fall_next   = cfg_wdata;
                tjpl_pkg::REG_LOSS:      loss_next   = cfg_wdata;
                tjpl_pkg::REG_PERIOD:    period_next = cfg_wdata;
                default:                 cfg_hit     = 1'b0;
            endcase
        end
        rh_next    = {1'b0, rise_next} + {1'b0, hold_next};
        total_next = {1'b0, rh_next} + {2'b00, fall_next};
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        we_next        = we_reg;
        count_next     = count_reg;
        restart_next   = restart_reg;
        now_next       = now_reg;
        after_end_next = after_end_reg;
        diff_next      = diff_reg;
        x_next         = x_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        res_drop_next  = res_drop_reg;
        res_delay_next = res_delay_reg;
        out_valid_next = out_valid_reg;
        out_drop_next  = out_drop_reg;
        out_delay_next = out_delay_reg;
        s_tready       = 1'b0;

        md_req.start        = 1'b0;
        md_req.multiplicand = amp_reg;
        md_req.multiplier   = num_reg;
        md_req.divisor      = den_reg;

        now_in    = s_tdata[TW-1:0];
        x_wide    = WW'(x_reg);
        rem_wide  = WW'(total_reg) - x_wide;
        count_inc = count_reg + 1'b1;

        // drain the output register
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tjpl_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    now_next = now_in;
                    if (restart_reg)
                    begin
                        ws_next      = now_in;
                        we_next      = now_in + TW'(total_reg);
                        count_next   = '0;
                        restart_next = 1'b0;
                    end
                    state_next = tjpl_pkg::ST_ADVANCE;
                end
            end
            tjpl_pkg::ST_ADVANCE:
            begin
                res_drop_next  = 1'b0;
                res_delay_next = '0;
                after_end_next = now_reg > we_reg;
                diff_next      = now_reg - we_reg;
                // zero amplitude: no window movement, zero result
                if (amp_reg == '0)
                begin
                    state_next = tjpl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = tjpl_pkg::ST_MOVE;
                end
            end
            tjpl_pkg::ST_MOVE:
            begin
                if (after_end_reg)
                begin
                    if (diff_reg > TW'(period_reg))
                    begin
                        ws_next = now_reg;
                        we_next = now_reg + TW'(total_reg);
                    end
                    else
                    begin
                        ws_next = ws_reg + TW'(period_reg);
                        we_next = we_reg + TW'(period_reg);
                    end
                    count_next = '0;
                end
                state_next = tjpl_pkg::ST_OFFSET;
            end
            tjpl_pkg::ST_OFFSET:
            begin
                x_next = now_reg - ws_reg;
                if (now_reg >= ws_reg)
                begin
                    state_next = tjpl_pkg::ST_PHASE;
                end
                else
                begin
                    state_next = tjpl_pkg::ST_DONE;
                end
            end
            tjpl_pkg::ST_PHASE:
            begin
                priority if (x_wide > WW'(rh_reg))
                begin
                    // fall ramp; past the window end the remainder is zero
                    num_next = (x_wide <= WW'(total_reg)) ? rem_wide[CW-1:0] : '0;
                    den_next = fall_reg;
                    if (fall_reg == '0)
                    begin
                        state_next = tjpl_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tjpl_pkg::ST_MULT;
                    end
                end
                else if (x_wide > WW'(rise_reg))
                begin
                    res_delay_next = amp_reg;
                    if ((loss_reg != '0) && (count_inc == loss_reg))
                    begin
                        count_next    = '0;
                        res_drop_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                    state_next = tjpl_pkg::ST_DONE;
                end
                else
                begin
                    num_next = x_reg[CW-1:0];
                    den_next = rise_reg;
                    if (rise_reg == '0)
                    begin
                        state_next = tjpl_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tjpl_pkg::ST_MULT;
                    end
                end
            end
            tjpl_pkg::ST_MULT:
            begin
                md_req.start = 1'b1;
                state_next   = tjpl_pkg::ST_DIVIDE;
            end
            tjpl_pkg::ST_DIVIDE:
            begin
                if (md_rsp.done)
                begin
                    res_delay_next = md_rsp.quotient;
                    state_next     = tjpl_pkg::ST_DONE;
                end
            end
            tjpl_pkg::ST_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_drop_next  = res_drop_reg;
                    out_delay_next = res_delay_reg;
                    state_next     = tjpl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tjpl_pkg::ST_IDLE;
            end
        endcase

        // any write to a listed register restarts the window
        if (cfg_hit)
        begin
            restart_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_delay_reg;
    assign m_tuser  = out_drop_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tjpl_pkg::ST_DONE) && (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("finished item not loaded into the output register");

    a_drop_full_delay: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == amp_reg))
        else $error("dropped item without full amplitude delay");

    a_divider_owned: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg == tjpl_pkg::ST_DIVIDE))
        else $error("divider finished outside the divide step");

    a_ramp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (md_rsp.quotient <= amp_reg))
        else $error("ramp delay exceeds amplitude");
`endif

endmodule

`default_nettype wire

// ===== dv/trapezoid_jitter_profile_with_loss_unit_test.sv =====
// Self-checking testbench for trapezoid_jitter_profile_with_loss_unit: packet
// arrival times in, drop flag and added delay out, checked against an in-bench
// window predictor. Depends on tjpl_pkg and the block's RTL.
`default_nettype none

module trapezoid_jitter_profile_with_loss_unit_test;

    localparam int TW = tjpl_pkg::TIME_W;
    localparam int CW = tjpl_pkg::CFG_W;
    localparam int IW = tjpl_pkg::CFG_IDX_W;
    localparam int MAX_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [63:0] TIME_TOP = (64'd1 << TW) - 64'd1;
    localparam logic [CW-1:0] CFG_MAX = '1;
    // Indexes past the register list; the block ignores writes to them
    localparam logic [IW-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [IW-1:0] REG_UNUSED_7 = 3'd7;

    typedef struct {
        logic              drop;
        logic [CW-1:0]     delay;
    } impairment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [tjpl_pkg::S_DATA_W-1:0] s_tdata = '0;   // [47:0] now_us
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [tjpl_pkg::M_DATA_W-1:0] m_tdata;       // [31:0] delay_us
    logic m_tuser;                                // [0] drop
    logic cfg_wr_en = 1'b0;
    logic [IW-1:0] cfg_addr = '0;
    logic [CW-1:0] cfg_wdata = '0;

    trapezoid_jitter_profile_with_loss_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Register mirror and window state of the predictor
    logic [CW-1:0] amp_cfg = '0;
    logic [CW-1:0] rise_cfg = '0;
    logic [CW-1:0] hold_cfg = '0;
    logic [CW-1:0] fall_cfg = '0;
    logic [CW-1:0] loss_cfg = '0;
    logic [CW-1:0] period_cfg = '0;
    logic [TW-1:0] win_start = '0;
    logic [TW-1:0] win_end = '0;
    logic [CW-1:0] hold_count = '0;
    logic restart_due = 1'b1;

    logic [TW-1:0] arrival_queue[$];
    impairment_t expected_impairments[$];
    impairment_t head;
    int send_idle_pct = 29;
    int recv_idle_pct = 79;
    int results_seen = 0;
    int mismatch_count = 0;
    int stall_left = 0;
    logic stall_done = 1'b0;
    int cycle_count = 0;

    function automatic impairment_t predict_impairment(input logic [TW-1:0] now);
        impairment_t r;
        logic [63:0] span;
        logic [63:0] now_w;
        logic [63:0] x;
        logic [63:0] rem;
        span = 64'(rise_cfg) + 64'(hold_cfg) + 64'(fall_cfg);
        now_w = 64'(now);
        r.drop = 1'b0;
        r.delay = '0;
        if (restart_due)
        begin
            win_start = now;
            win_end = now + span[TW-1:0];
            hold_count = '0;
            restart_due = 1'b0;
        end
        if (amp_cfg != '0)
        begin
            if (now > win_end)
            begin
                // more than one period late: restart at this packet
                if (now_w - 64'(win_end) > 64'(period_cfg))
                begin
                    win_start = now;
                    win_end = now + span[TW-1:0];
                end
                else
                begin
                    win_start = win_start + TW'(period_cfg);
                    win_end = win_end + TW'(period_cfg);
                end
                hold_count = '0;
            end
            if (now >= win_start)
            begin
                x = now_w - 64'(win_start);
                if (x > 64'(rise_cfg) + 64'(hold_cfg))
                begin
                    rem = (x <= span) ? span - x : 64'd0;
                    if (fall_cfg != '0)
                        r.delay = 32'((64'(amp_cfg) * rem) / 64'(fall_cfg));
                end
                else if (x > 64'(rise_cfg))
                begin
                    hold_count = hold_count + 32'd1;
                    if (loss_cfg != '0 && hold_count == loss_cfg)
                    begin
                        hold_count = '0;
                        r.drop = 1'b1;
                    end
                    r.delay = amp_cfg;
                end
                else if (rise_cfg != '0)
                begin
                    r.delay = 32'((64'(amp_cfg) * x) / 64'(rise_cfg));
                end
            end
        end
        return r;
    endfunction

    task automatic set_register(input logic [IW-1:0] idx, input logic [CW-1:0] value);
        logic known;
        known = 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            tjpl_pkg::REG_AMPLITUDE: amp_cfg = value;
            tjpl_pkg::REG_RISE:      rise_cfg = value;
            tjpl_pkg::REG_HOLD:      hold_cfg = value;
            tjpl_pkg::REG_FALL:      fall_cfg = value;
            tjpl_pkg::REG_LOSS:      loss_cfg = value;
            tjpl_pkg::REG_PERIOD:    period_cfg = value;
            default:                 known = 1'b0;
        endcase
        if (known)
            restart_due = 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every item is in and every result is out, then let the block go quiet
    task automatic drain_block();
        do
            @(negedge clk);
        while (arrival_queue.size() != 0 || s_tvalid || expected_impairments.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] pick_ramp();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    // Packet sender: hold the item until taken, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_impairments.push_back(predict_impairment(s_tdata[TW-1:0]));
            if (!s_tvalid || s_tready)
            begin
                if (arrival_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata <= tjpl_pkg::S_DATA_W'(arrival_queue.pop_front());
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_impairments.size() == 0)
                begin
                    $error("unexpected result item: drop %0b delay_us %0d", m_tuser, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    head = expected_impairments.pop_front();
                    if (m_tuser !== head.drop)
                    begin
                        $error("drop: expected %0b, got %0b", head.drop, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata !== head.delay)
                    begin
                        $error("delay_us: expected %0d, got %0d", head.delay, m_tdata);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold off the receiver once for a long stretch so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (!stall_done && results_seen >= 200)
        begin
            stall_left <= 1500;
            stall_done <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("trapezoid_jitter_profile_with_loss_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] clock_us;
        logic [63:0] span;
        logic [63:0] period_w;
        logic [CW-1:0] rv;
        logic [CW-1:0] hv;
        logic [CW-1:0] fv;
        int unsigned pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset the amplitude is zero: nothing is delayed or dropped
        @(negedge clk);
        arrival_queue.push_back(TW'(0));
        arrival_queue.push_back(TW'(TIME_TOP));
        drain_block();

        // Walk one window: rise, hold with every third packet dropped, fall,
        // advance by one period, arrival before the window, late restart
        set_register(tjpl_pkg::REG_AMPLITUDE, 32'd1000);
        set_register(tjpl_pkg::REG_RISE, 32'd100);
        set_register(tjpl_pkg::REG_HOLD, 32'd50);
        set_register(tjpl_pkg::REG_FALL, 32'd200);
        set_register(tjpl_pkg::REG_LOSS, 32'd3);
        set_register(tjpl_pkg::REG_PERIOD, 32'd1000);
        @(negedge clk);
        arrival_queue.push_back(TW'(5000));
        arrival_queue.push_back(TW'(5050));
        arrival_queue.push_back(TW'(5100));
        arrival_queue.push_back(TW'(5101));
        arrival_queue.push_back(TW'(5120));
        arrival_queue.push_back(TW'(5150));
        arrival_queue.push_back(TW'(5151));
        arrival_queue.push_back(TW'(5250));
        arrival_queue.push_back(TW'(5350));
        arrival_queue.push_back(TW'(5400));
        arrival_queue.push_back(TW'(6100));
        arrival_queue.push_back(TW'(6000));
        arrival_queue.push_back(TW'(7400));
        drain_block();

        // Writes to unused indexes must not restart the window
        set_register(REG_UNUSED_6, 32'd5);
        set_register(REG_UNUSED_7, CFG_MAX);
        @(negedge clk);
        arrival_queue.push_back(TW'(7450));
        drain_block();

        // Full-scale registers, then a restart at the top of the time range
        set_register(tjpl_pkg::REG_AMPLITUDE, CFG_MAX);
        set_register(tjpl_pkg::REG_RISE, CFG_MAX);
        set_register(tjpl_pkg::REG_HOLD, '0);
        set_register(tjpl_pkg::REG_FALL, CFG_MAX);
        set_register(tjpl_pkg::REG_LOSS, CFG_MAX);
        set_register(tjpl_pkg::REG_PERIOD, '0);
        @(negedge clk);
        arrival_queue.push_back(TW'(1000));
        arrival_queue.push_back(TW'(1000 + 64'h8000_0000));
        arrival_queue.push_back(TW'(1000 + 64'h1_0000_0000));
        arrival_queue.push_back(TW'(TIME_TOP));
        arrival_queue.push_back(TW'(5));
        drain_block();

        // Zero-length ramps, drop on every hold packet, zero period
        set_register(tjpl_pkg::REG_AMPLITUDE, 32'd7);
        set_register(tjpl_pkg::REG_RISE, '0);
        set_register(tjpl_pkg::REG_HOLD, 32'd10);
        set_register(tjpl_pkg::REG_FALL, '0);
        set_register(tjpl_pkg::REG_LOSS, 32'd1);
        set_register(tjpl_pkg::REG_PERIOD, '0);
        @(negedge clk);
        arrival_queue.push_back(TW'(100));
        arrival_queue.push_back(TW'(105));
        arrival_queue.push_back(TW'(110));
        arrival_queue.push_back(TW'(111));
        arrival_queue.push_back(TW'(112));

        for (int p = 0; p < 12; p++)
        begin
            drain_block();
            if (p == 4)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 29;
            end
            if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                3:
                begin
                    set_register(tjpl_pkg::REG_AMPLITUDE, CFG_MAX);
                    set_register(tjpl_pkg::REG_RISE, CFG_MAX);
                    set_register(tjpl_pkg::REG_HOLD, CFG_MAX);
                    set_register(tjpl_pkg::REG_FALL, CFG_MAX);
                    set_register(tjpl_pkg::REG_LOSS, 32'd2);
                    set_register(tjpl_pkg::REG_PERIOD, CFG_MAX);
                end
                7:
                begin
                    set_register(tjpl_pkg::REG_AMPLITUDE, $urandom);
                    set_register(tjpl_pkg::REG_RISE, '0);
                    set_register(tjpl_pkg::REG_HOLD, $urandom_range(0, 300));
                    set_register(tjpl_pkg::REG_FALL, '0);
                    set_register(tjpl_pkg::REG_LOSS, 32'd1);
                    set_register(tjpl_pkg::REG_PERIOD, '0);
                end
                10:
                begin
                    // block disabled, window frozen
                    set_register(tjpl_pkg::REG_AMPLITUDE, '0);
                    set_register(tjpl_pkg::REG_RISE, pick_ramp());
                end
                default:
                begin
                    case ($urandom_range(5))
                        0:       set_register(tjpl_pkg::REG_AMPLITUDE, 32'd1);
                        1:       set_register(tjpl_pkg::REG_AMPLITUDE, CFG_MAX);
                        2:       set_register(tjpl_pkg::REG_AMPLITUDE, $urandom);
                        default: set_register(tjpl_pkg::REG_AMPLITUDE,
                                              $urandom_range(1, 5000));
                    endcase
                    rv = pick_ramp();
                    hv = pick_ramp();
                    fv = pick_ramp();
                    set_register(tjpl_pkg::REG_RISE, rv);
                    set_register(tjpl_pkg::REG_HOLD, hv);
                    set_register(tjpl_pkg::REG_FALL, fv);
                    case ($urandom_range(5))
                        0:       set_register(tjpl_pkg::REG_LOSS, '0);
                        1:       set_register(tjpl_pkg::REG_LOSS, $urandom);
                        2:       set_register(tjpl_pkg::REG_LOSS, CFG_MAX);
                        default: set_register(tjpl_pkg::REG_LOSS, $urandom_range(1, 5));
                    endcase
                    span = 64'(rv) + 64'(hv) + 64'(fv);
                    case ($urandom_range(5))
                        0:       period_w = 64'd0;
                        1:       period_w = 64'(CFG_MAX);
                        2:       period_w = (span * 64'($urandom_range(0, 1023))) >> 10;
                        default: period_w = span + 64'($urandom_range(0, 300));
                    endcase
                    if (period_w > 64'(CFG_MAX))
                        period_w = 64'(CFG_MAX);
                    set_register(tjpl_pkg::REG_PERIOD, period_w[CW-1:0]);
                end
            endcase
            if ($urandom_range(3) == 0)
                set_register(REG_UNUSED_7, $urandom);

            @(negedge clk);
            span = 64'(rise_cfg) + 64'(hold_cfg) + 64'(fall_cfg);
            case ($urandom_range(3))
                0:       clock_us = {$urandom, $urandom};
                1:       clock_us = TIME_TOP - 64'($urandom_range(0, 2000));
                default: clock_us = 64'($urandom_range(0, 100000));
            endcase
            for (int i = 0; i < 115; i++)
            begin
                // mostly steps through the window, some period-sized moves,
                // late restarts, repeats, and a little out-of-order noise
                pick = $urandom_range(99);
                if (pick < 60)
                    clock_us = clock_us + ((span * 64'($urandom_range(0, 400))) >> 10)
                               + 64'($urandom_range(0, 3));
                else if (pick < 75)
                    clock_us = clock_us + 64'(period_cfg) + 64'($urandom_range(0, 2));
                else if (pick < 85)
                    clock_us = clock_us + 64'(period_cfg) + span
                               + 64'($urandom_range(1, 64));
                else if (pick < 90)
                    clock_us = clock_us - 64'($urandom_range(1, 50));
                else if (pick < 92)
                    clock_us = {$urandom, $urandom};
                arrival_queue.push_back(TW'(clock_us));
            end
        end

        drain_block();
        if (mismatch_count == 0 && expected_impairments.size() == 0)
            $display("trapezoid_jitter_profile_with_loss_unit_test: clean");
        else
            $display("trapezoid_jitter_profile_with_loss_unit_test: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/tjpl_pkg.sv
sv/tjpl_muldiv.sv
sv/trapezoid_jitter_profile_with_loss_unit.sv
dv/trapezoid_jitter_profile_with_loss_unit_test.sv
